// File: hdl/ipd_pkg.sv
// ----------------------------------------------------------------------------
// ipd_pkg: shared types and constants of the IMU packet deframer
// Holds the packet framing constants, the byte window type and the
// control bundle that passes between the window and the result stage.
// ----------------------------------------------------------------------------
package ipd_pkg;

    localparam int PACKET_BYTES = 15;
    localparam int FILL_W       = 4;
    localparam int SUM_FIRST    = 2;
    localparam int SUM_LAST     = 13;
    localparam int SUM_TERMS    = SUM_LAST - SUM_FIRST + 1;

    localparam logic [7:0] SYNC_BYTE   = 8'hAA;
    localparam logic [7:0] SECOND_BYTE = 8'h00;

    localparam logic [FILL_W-1:0] FILL_FULL   = FILL_W'(PACKET_BYTES);
    localparam logic [FILL_W-1:0] FILL_LAST   = FILL_W'(PACKET_BYTES - 1);

    // Element 0 is the oldest byte, element PACKET_BYTES-1 the newest.
    typedef logic [PACKET_BYTES-1:0][7:0] window_t;

    // Handshake between the result stage and the window stage.
    typedef struct packed {
        logic consume;   // a matched window moves into the result register
        logic stall;     // a matched window waits on a full result register
    } frame_ctrl_t;

endpackage

// File: hdl/ipd_byte_if.sv
// ----------------------------------------------------------------------------
// ipd_byte_if: received byte channel
// One serial byte per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ipd_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);

endinterface

// File: hdl/ipd_result_if.sv
// ----------------------------------------------------------------------------
// ipd_result_if: decoded IMU sample channel
// Five raw signed 16-bit fields per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ipd_result_if;

    logic               valid;
    logic               ready;
    logic signed [15:0] angle_word;
    logic signed [15:0] rate_word;
    logic signed [15:0] accel_x_raw;
    logic signed [15:0] accel_y_raw;
    logic signed [15:0] accel_z_raw;

    modport source (
        output valid, output angle_word, output rate_word,
        output accel_x_raw, output accel_y_raw, output accel_z_raw,
        input ready
    );
    modport sink (
        input valid, input angle_word, input rate_word,
        input accel_x_raw, input accel_y_raw, input accel_z_raw,
        output ready
    );

endinterface

// File: hdl/ipd_window.sv
// ----------------------------------------------------------------------------
// ipd_window: byte window and fill tracking
// Shifts accepted bytes into the window, counts bytes since reset or since
// the last packet and flags a full window for a check, kept during a stall.
// ----------------------------------------------------------------------------
module ipd_window (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    input  ipd_pkg::frame_ctrl_t ctrl,
    output ipd_pkg::window_t     window,
    output logic                 cand
);
    import ipd_pkg::*;

    window_t           window_reg;
    window_t           window_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              cand_reg;
    logic              cand_next;
    logic [FILL_W-1:0] fill_eff;

    // A packet leaving for the result register restarts the count.
    assign fill_eff = ctrl.consume ? '0 : fill_reg;

    always_comb
    begin
        window_next = window_reg;
        fill_next   = fill_eff;
        cand_next   = ctrl.stall;
        if (accept)
        begin
            window_next = {rx_byte, window_reg[PACKET_BYTES-1:1]};
            fill_next   = (fill_eff == FILL_FULL) ? FILL_FULL : fill_eff + FILL_W'(1);
            cand_next   = (fill_eff == FILL_LAST) || (fill_eff == FILL_FULL);
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            cand_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            cand_reg <= cand_next;
        end
    end

    assign window = window_reg;
    assign cand   = cand_reg;

endmodule

// File: hdl/ipd_check.sv
// ----------------------------------------------------------------------------
// ipd_check: packet recognizer
// Compares the header bytes and the 8-bit sum of the payload bytes
// against the checksum byte of a full window.
// ----------------------------------------------------------------------------
module ipd_check (
    input  ipd_pkg::window_t window,
    input  logic             cand,
    output logic             match
);
    import ipd_pkg::*;

    logic [7:0] sum_l1 [SUM_TERMS/2];
    logic [7:0] sum_l2 [SUM_TERMS/4];
    logic [7:0] sum_total;
    logic       header_ok;

    // Add the twelve payload bytes as a tree: pairs, then groups of four.
    always_comb
    begin
        for (int i = 0; i < SUM_TERMS / 2; i++)
        begin
            sum_l1[i] = window[SUM_FIRST + 2 * i] + window[SUM_FIRST + 2 * i + 1];
        end
        for (int i = 0; i < SUM_TERMS / 4; i++)
        begin
            sum_l2[i] = sum_l1[2 * i] + sum_l1[2 * i + 1];
        end
    end

    assign sum_total = sum_l2[0] + sum_l2[1] + sum_l2[2];
    assign header_ok = (window[0] == SYNC_BYTE) && (window[1] == SECOND_BYTE);
    assign match     = cand && header_ok && (sum_total == window[PACKET_BYTES-1]);

endmodule

// File: hdl/ipd_result.sv
// ----------------------------------------------------------------------------
// ipd_result: result register
// Unpacks the little-endian fields of a matched window and holds them
// until the downstream side takes the transaction.
// ----------------------------------------------------------------------------
module ipd_result (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ipd_pkg::window_t     window,
    input  logic                 match,
    output ipd_pkg::frame_ctrl_t ctrl,
    ipd_result_if.source         imu
);
    import ipd_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic signed [15:0] angle_reg;
    logic signed [15:0] rate_reg;
    logic signed [15:0] accel_x_reg;
    logic signed [15:0] accel_y_reg;
    logic signed [15:0] accel_z_reg;
    logic               slot_free;

    assign slot_free    = !valid_reg || imu.ready;
    assign ctrl.consume = match && slot_free;
    assign ctrl.stall   = match && !slot_free;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.consume)
        begin
            valid_next = 1'b1;
        end
        else if (imu.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the payload only with a new packet.
    always_ff @(posedge clk)
    begin
        if (ctrl.consume)
        begin
            angle_reg   <= {window[4], window[3]};
            rate_reg    <= {window[6], window[5]};
            accel_x_reg <= {window[8], window[7]};
            accel_y_reg <= {window[10], window[9]};
            accel_z_reg <= {window[12], window[11]};
        end
    end

    assign imu.valid       = valid_reg;
    assign imu.angle_word  = angle_reg;
    assign imu.rate_word   = rate_reg;
    assign imu.accel_x_raw = accel_x_reg;
    assign imu.accel_y_raw = accel_y_reg;
    assign imu.accel_z_raw = accel_z_reg;

endmodule

// File: hdl/imu_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// imu_packet_deframer_top: serial IMU packet deframer
// Finds 15-byte sum-checked packets in a byte stream and emits raw samples.
// ----------------------------------------------------------------------------
// The block takes one received byte per transaction on rx and can accept a
// byte in every clock cycle. It keeps the last 15 bytes; once 15 bytes have
// arrived since reset or since the last packet, each new window is checked:
// byte 0 must be 0xAA, byte 1 must be 0x00 and the 8-bit sum of bytes 2 to
// 13 must equal byte 14. A match passes from the window register into the
// result register and produces one transaction on imu, carrying angle,
// rate and the three acceleration values as raw signed little-endian
// 16-bit numbers (hundredths and thousandths, no scaling). After a match
// the count restarts, so the next packet needs 15 fresh bytes. The result
// register decouples the two sides: rx stalls only while a matched packet
// waits behind an untaken result.
// ----------------------------------------------------------------------------
module imu_packet_deframer_top (
    input  logic         clk,
    input  logic         rst_n,
    ipd_byte_if.sink     rx,
    ipd_result_if.source imu
);
    import ipd_pkg::*;

    window_t     window;
    logic        cand;
    logic        match;
    logic        accept;
    frame_ctrl_t ctrl;

    // Hold rx only while a found packet cannot move into the result register.
    assign rx.ready = !ctrl.stall;
    assign accept   = rx.valid && rx.ready;

    // Shift the byte in and advance the fill count.
    ipd_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx.rx_byte),
        .ctrl    (ctrl),
        .window  (window),
        .cand    (cand)
    );

    // Check header and checksum of the registered window.
    ipd_check u_check (
        .window (window),
        .cand   (cand),
        .match  (match)
    );

    // Unpack the fields and hold the transaction for downstream.
    ipd_result u_result (
        .clk    (clk),
        .rst_n  (rst_n),
        .window (window),
        .match  (match),
        .ctrl   (ctrl),
        .imu    (imu)
    );

endmodule

// File: sim/tb_imu_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// tb_imu_packet_deframer_top: self-checking bench for the IMU packet deframer
// Feeds received bytes through the rx channel, keeps a shadow byte window to
// work out which windows form sum-checked packets, and compares every decoded
// sample on the imu channel with the oldest pending one. Both channels idle
// at random, with runs of back-to-back traffic in between.
// ----------------------------------------------------------------------------
module tb_imu_packet_deframer_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ipd_pkg::*;

    // One decoded sample, in the order the result channel carries it.
    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] rate;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } sample_t;

    // How a directed row gets its expectation: typed in as "no sample",
    // typed in as the extreme-value sample, or taken from the shadow model.
    typedef enum logic [1:0] {
        ROW_NONE,
        ROW_SAMPLE,
        ROW_MODEL
    } row_kind_e;

    typedef struct packed {
        logic [7:0] data;
        row_kind_e  kind;
    } row_t;

    // Damage applied to a generated packet.
    typedef enum logic [2:0] {
        FLAW_NONE,
        FLAW_SYNC,
        FLAW_SECOND,
        FLAW_SUM,
        FLAW_SHORT
    } flaw_e;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_BYTES  = 900;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 20;

    // Every field at an extreme: angle minimum, rate maximum, accel x minus
    // one, accel y zero, accel z one. Byte 2 is 0xFF and only feeds the sum.
    localparam sample_t EDGE_SAMPLE = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001};

    // Directed stimulus. The first 14 bytes after reset cannot match since
    // the window is not yet full; byte 15 completes the extreme packet. The
    // ten bytes after it look like sync patterns, but the count restarted on
    // the match, so the shadow model must report nothing for them.
    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'hAA, ROW_NONE}, '{8'h00, ROW_NONE}, '{8'hFF, ROW_NONE},
        '{8'h00, ROW_NONE}, '{8'h80, ROW_NONE}, '{8'hFF, ROW_NONE},
        '{8'h7F, ROW_NONE}, '{8'hFF, ROW_NONE}, '{8'hFF, ROW_NONE},
        '{8'h00, ROW_NONE}, '{8'h00, ROW_NONE}, '{8'h01, ROW_NONE},
        '{8'h00, ROW_NONE}, '{8'h00, ROW_NONE}, '{8'hFC, ROW_SAMPLE},
        '{8'hAA, ROW_MODEL}, '{8'h00, ROW_MODEL}, '{8'hAA, ROW_MODEL},
        '{8'h00, ROW_MODEL}, '{8'hFF, ROW_MODEL}, '{8'h00, ROW_MODEL},
        '{8'hAA, ROW_MODEL}, '{8'h00, ROW_MODEL}, '{8'h12, ROW_MODEL},
        '{8'h34, ROW_MODEL}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ipd_byte_if   rx_if ();
    ipd_result_if imu_if ();

    imu_packet_deframer_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .imu   (imu_if)
    );

    // Shadow copy of the deframer state.
    logic [7:0]        shadow_window [PACKET_BYTES];
    logic [FILL_W-1:0] shadow_fill;

    sample_t pending_samples [$];

    int unsigned bytes_sent;
    int unsigned frames_good;
    int unsigned frames_damaged;
    int unsigned samples_checked;
    int unsigned mismatch_count;
    int unsigned stray_samples;
    bit          src_idle_on;
    bit          sink_idle_on;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shift one byte into the shadow window and tell whether the window now
    // holds a packet; on a match, decode the sample and restart the count.
    function automatic void deframe_byte(input logic [7:0] b, output logic hit,
                                         output sample_t s);
        logic [7:0] sum;
        for (int k = 0; k < PACKET_BYTES - 1; k++)
            shadow_window[k] = shadow_window[k + 1];
        shadow_window[PACKET_BYTES - 1] = b;
        if (shadow_fill != FILL_FULL)
            shadow_fill = shadow_fill + FILL_W'(1);
        sum = '0;
        for (int k = SUM_FIRST; k <= SUM_LAST; k++)
            sum = sum + shadow_window[k];
        hit = (shadow_fill == FILL_FULL) && (shadow_window[0] == SYNC_BYTE)
              && (shadow_window[1] == SECOND_BYTE)
              && (sum == shadow_window[PACKET_BYTES - 1]);
        s.angle   = {shadow_window[4],  shadow_window[3]};
        s.rate    = {shadow_window[6],  shadow_window[5]};
        s.accel_x = {shadow_window[8],  shadow_window[7]};
        s.accel_y = {shadow_window[10], shadow_window[9]};
        s.accel_z = {shadow_window[12], shadow_window[11]};
        if (hit)
            shadow_fill = '0;
    endfunction

    // Send one byte: idle for a random gap, hold it until the deframer takes
    // it, then advance the shadow state and record what sample is due.
    task automatic send_byte(input logic [7:0] b, input row_kind_e kind);
        int unsigned gap;
        logic        hit;
        sample_t     s;
        // Re-draw the idling mode now and then so that runs with no gaps
        // alternate with runs of random gaps.
        if (bytes_sent % 64 == 0)
            src_idle_on = ($urandom_range(0, 3) != 0);
        gap = src_idle_on ? $urandom_range(0, 5) : 0;
        if (gap != 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        deframe_byte(b, hit, s);
        case (kind)
            ROW_SAMPLE: pending_samples.push_back(EDGE_SAMPLE);
            ROW_MODEL:  if (hit) pending_samples.push_back(s);
            default:    ;
        endcase
        bytes_sent++;
    endtask

    // Random payload byte, biased toward the all-zero and all-one values.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Build a packet with random content, optionally damage it, and send it.
    task automatic send_frame(input flaw_e flaw);
        logic [7:0]  frame [PACKET_BYTES];
        logic [7:0]  sum;
        int unsigned len;
        sum = '0;
        frame[0] = SYNC_BYTE;
        frame[1] = SECOND_BYTE;
        for (int k = SUM_FIRST; k <= SUM_LAST; k++)
        begin
            frame[k] = pick_byte();
            sum = sum + frame[k];
        end
        frame[PACKET_BYTES - 1] = sum;
        len = PACKET_BYTES;
        case (flaw)
            FLAW_SYNC:   frame[0] = SYNC_BYTE ^ 8'($urandom_range(1, 255));
            FLAW_SECOND: frame[1] = 8'($urandom_range(1, 255));
            FLAW_SUM:    frame[PACKET_BYTES - 1] = sum + 8'($urandom_range(1, 255));
            FLAW_SHORT:  len = $urandom_range(2, PACKET_BYTES - 1);
            default:     ;
        endcase
        if (flaw == FLAW_NONE)
            frames_good++;
        else
            frames_damaged++;
        for (int k = 0; k < len; k++)
            send_byte(frame[k], ROW_MODEL);
    endtask

    // Main stimulus: reset, directed table, random traffic, drain, verdict.
    initial
    begin
        int unsigned choice;
        int unsigned burst;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        for (int k = 0; k < PACKET_BYTES; k++)
            shadow_window[k] = '0;
        shadow_fill = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table.
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_byte(DIRECTED[r].data, DIRECTED[r].kind);

        // Random traffic: mostly well-formed packets with random content,
        // the rest damaged or cut-short packets and bursts of line noise.
        while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES)
        begin
            choice = $urandom_range(0, 15);
            if (choice <= 9)
                send_frame(FLAW_NONE);
            else if (choice == 10)
                send_frame(FLAW_SYNC);
            else if (choice == 11)
                send_frame(FLAW_SECOND);
            else if (choice == 12)
                send_frame(FLAW_SUM);
            else if (choice == 13)
                send_frame(FLAW_SHORT);
            else
            begin
                burst = $urandom_range(1, 8);
                repeat (burst) send_byte(8'($urandom_range(0, 255)), ROW_MODEL);
            end
        end
        rx_if.valid <= 1'b0;

        // Drain: wait for every due sample, then hold a little longer so a
        // stray extra sample would still be caught.
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes: %0d intact and %0d damaged or cut-short packets.",
                 bytes_sent, frames_good, frames_damaged);
        $display("Checked %0d decoded samples under random idling on both channels.",
                 samples_checked);
        if (mismatch_count == 0 && stray_samples == 0 && pending_samples.size() == 0)
            $display("imu_packet_deframer_top: match");
        else
            $display("imu_packet_deframer_top: mismatch");
        $finish;
    end

    // Result sink: drop ready for a random number of cycles before each
    // transaction, with stretches of constant ready in between.
    initial
    begin
        int unsigned gap;
        int unsigned taken;
        taken = 0;
        imu_if.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (taken % 32 == 0)
                sink_idle_on = ($urandom_range(0, 3) != 0);
            gap = sink_idle_on ? $urandom_range(0, 5) : 0;
            if (gap != 0)
            begin
                imu_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            imu_if.ready <= 1'b1;
            do @(posedge clk); while (!imu_if.valid);
            taken++;
        end
    end

    // Compare each accepted sample with the oldest pending one.
    always @(posedge clk)
    begin
        sample_t got;
        sample_t want;
        if (rst_n && imu_if.valid && imu_if.ready)
        begin
            got = '{imu_if.angle_word, imu_if.rate_word, imu_if.accel_x_raw,
                    imu_if.accel_y_raw, imu_if.accel_z_raw};
            if (pending_samples.size() == 0)
            begin
                stray_samples++;
                if (mismatch_count + stray_samples <= MAX_REPORTS)
                    $display("unexpected sample: angle %0d rate %0d acc %0d %0d %0d",
                             got.angle, got.rate, got.accel_x, got.accel_y, got.accel_z);
            end
            else
            begin
                want = pending_samples.pop_front();
                samples_checked++;
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count + stray_samples <= MAX_REPORTS)
                    begin
                        $display("sample %0d expected: angle %0d rate %0d acc %0d %0d %0d",
                                 samples_checked, want.angle, want.rate, want.accel_x,
                                 want.accel_y, want.accel_z);
                        $display("sample %0d actual:   angle %0d rate %0d acc %0d %0d %0d",
                                 samples_checked, got.angle, got.rate, got.accel_x,
                                 got.accel_y, got.accel_z);
                    end
                end
            end
        end
    end

    // Hang guard: end the run if the traffic never drains.
    initial
    begin
        #5ms;
        $display("timeout waiting on the deframer");
        $display("imu_packet_deframer_top: mismatch");
        $finish;
    end

endmodule
